[rtl/core/pfg_pkg.sv]
// Shared constants, types and lookup functions for the field gather and velocity push block.
package pfg_pkg;

    localparam int GRID_X   = 64;
    localparam int GRID_Y   = 64;
    localparam int NCOLS    = GRID_X + 3;
    localparam int DEPTH    = NCOLS * GRID_Y;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COL_W    = $clog2(NCOLS);
    localparam int ROW_W    = $clog2(GRID_Y);
    localparam int IX_W     = $clog2(GRID_X);
    localparam int NY_W     = 7;
    localparam int POT_W    = 32;
    localparam int D_W      = 34;
    localparam int LO_W     = 17;
    localparam int PLO_W    = D_W + LO_W;
    localparam int PHI_W    = D_W + 16;
    localparam int FULL_W   = PHI_W + 16;
    localparam int TERM_W   = FULL_W - 24;
    localparam int DIFF_W   = TERM_W + 1;
    localparam int LPROD_W  = DIFF_W + LO_W;
    localparam int LSH_W    = LPROD_W - 16;
    localparam int SUM_W    = TERM_W + 1;
    localparam int NPOT     = 12;
    localparam int NTERM    = 8;
    localparam int NLERP    = 6;
    localparam int CNT_W    = 4;
    localparam int PADDR_W  = 5;
    localparam int NY_MIN   = 2;

    typedef enum logic [2:0] {
        REG_EX_SCALE  = 3'd0,
        REG_EY_SCALE  = 3'd1,
        REG_EX_OFFSET = 3'd2,
        REG_EY_OFFSET = 3'd3,
        REG_NY_USED   = 3'd4
    } t_reg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PUSH  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ROW_L  = 2'd0,
        ROW_H  = 2'd1,
        ROW_M  = 2'd2,
        ROW_HP = 2'd3
    } t_row_sel;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MOD  = 3'd1,
        S_READ = 3'd2,
        S_TERM = 3'd3,
        S_LERP = 3'd4,
        S_DONE = 3'd5
    } t_state;

    typedef struct packed {
        logic              command;
        logic [6:0]        cell_x;
        logic [5:0]        cell_y;
        logic signed [31:0] potential;
        logic signed [31:0] pos_x;
        logic [21:0]       pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic              absent;
        logic              saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] ex_scale;
        logic signed [31:0] ey_scale;
        logic signed [31:0] ex_offset;
        logic signed [31:0] ey_offset;
        logic [NY_W-1:0]    ny_used;
    } t_cfg;

    typedef struct packed {
        logic             accept;
        logic             mod_step;
        logic             rd_en;
        logic             cap_en;
        logic             mul_lo;
        logic             mul_hi;
        logic             lerp_en;
        logic             emit;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic push;
        logic absent;
        logic out_free;
    } t_dp_stat;

    // column offset from grid x minus one, per read slot
    function automatic logic [1:0] pot_col_off(input logic [CNT_W-1:0] i);
        logic [1:0] r;
        unique case (i)
            4'd0, 4'd2:                      r = 2'd0;
            4'd1, 4'd3, 4'd9, 4'd11:         r = 2'd2;
            4'd4, 4'd6, 4'd8, 4'd10:         r = 2'd1;
            4'd5, 4'd7:                      r = 2'd3;
            default:                         r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic t_row_sel pot_row(input logic [CNT_W-1:0] i);
        t_row_sel r;
        unique case (i)
            4'd0, 4'd1, 4'd4, 4'd5:  r = ROW_L;
            4'd2, 4'd3, 4'd6, 4'd7:  r = ROW_H;
            4'd8, 4'd9:              r = ROW_M;
            default:                 r = ROW_HP;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] term_pos(input logic [2:0] j);
        logic [CNT_W-1:0] r;
        unique case (j)
            3'd0: r = 4'd1;
            3'd1: r = 4'd3;
            3'd2: r = 4'd5;
            3'd3: r = 4'd7;
            3'd4: r = 4'd6;
            3'd5: r = 4'd10;
            3'd6: r = 4'd3;
            default: r = 4'd11;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] term_neg(input logic [2:0] j);
        logic [CNT_W-1:0] r;
        unique case (j)
            3'd0: r = 4'd0;
            3'd1: r = 4'd2;
            3'd2: r = 4'd4;
            3'd3: r = 4'd6;
            3'd4: r = 4'd8;
            3'd5: r = 4'd4;
            3'd6: r = 4'd9;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/pfg_in_if.sv]
// Input channel carrying write and push items.
interface pfg_in_if;
    import pfg_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/pfg_out_if.sv]
// Output channel carrying advanced velocity items.
interface pfg_out_if;
    import pfg_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/pic_field_gather_velocity_push_2d.sv]
// Top level: 2-D grid field gather and velocity push.
//  channel  | dir | carries
//  i_in     | in  | potential write or particle push item
//  o_out    | out | advanced velocity, absent and saturated flags
//  APB      | in  | scale, offset and rows-in-use registers
// A write item is stored in the grid as it is accepted. A push item passes the row wrap,
// twelve reads through the single grid read port, eight field terms on the shared
// two-pass multiplier and 6 interpolation steps, then loads the output once the output
// register is free, an absent one directly. A finished item waits in the output register
// while the next one is accepted. Reset is synchronous; the grid holds no reset value.
module pic_field_gather_velocity_push_2d (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pfg_in_if.sink                      i_in,
    pfg_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pfg_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    pfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pfg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (i_in.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );
endmodule

[rtl/core/pfg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/pfg_regs.sv]
// APB-style configuration register file.
module pfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfg_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pfg_pkg::t_cfg                 o_cfg
);
    import pfg_pkg::*;

    t_cfg r_cfg;
    logic wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ex_scale  <= '0;
            r_cfg.ey_scale  <= '0;
            r_cfg.ex_offset <= '0;
            r_cfg.ey_offset <= '0;
            r_cfg.ny_used   <= NY_W'(GRID_Y);
        end else if (wr) begin
            unique case (idx)
                REG_EX_SCALE:  r_cfg.ex_scale  <= pwdata;
                REG_EY_SCALE:  r_cfg.ey_scale  <= pwdata;
                REG_EX_OFFSET: r_cfg.ex_offset <= pwdata;
                REG_EY_OFFSET: r_cfg.ey_offset <= pwdata;
                REG_NY_USED:   r_cfg.ny_used   <= pwdata[NY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_EX_SCALE:  prdata = r_cfg.ex_scale;
            REG_EY_SCALE:  prdata = r_cfg.ey_scale;
            REG_EX_OFFSET: prdata = r_cfg.ex_offset;
            REG_EY_OFFSET: prdata = r_cfg.ey_offset;
            REG_NY_USED:   prdata = 32'(r_cfg.ny_used);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

[rtl/core/pfg_ctrl.sv]
// Sequencer for row wrap, grid reads, field terms and interpolation.
module pfg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfg_pkg::t_dp_stat  i_stat,
    output pfg_pkg::t_dp_cmd   o_cmd
);
    import pfg_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.push) begin
                        if (i_stat.absent) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MOD;
                            n_cnt   = CNT_W'(ROW_W - 1);
                        end
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.idx      = r_cnt;
                if (r_cnt == '0) begin
                    n_state = S_READ;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_en  = (r_cnt < CNT_W'(NPOT));
                o_cmd.cap_en = (r_cnt != '0);
                o_cmd.idx    = r_cnt;
                if (r_cnt == CNT_W'(NPOT)) begin
                    n_state = S_TERM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TERM: begin
                o_cmd.idx    = {1'b0, r_cnt[CNT_W-1:1]};
                o_cmd.mul_lo = !r_cnt[0];
                o_cmd.mul_hi = r_cnt[0];
                if (r_cnt == CNT_W'(2 * NTERM - 1)) begin
                    n_state = S_LERP;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LERP: begin
                o_cmd.lerp_en = 1'b1;
                o_cmd.idx     = r_cnt;
                if (r_cnt == CNT_W'(NLERP - 1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/core/pfg_dpath.sv]
// Potential grid, field term arithmetic, interpolation and output register.
module pfg_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfg_pkg::t_cfg         i_cfg,
    input  pfg_pkg::t_in_item     i_item,
    input  pfg_pkg::t_dp_cmd      i_cmd,
    output pfg_pkg::t_dp_stat     o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pfg_pkg::t_out_item    o_out_data
);
    import pfg_pkg::*;

    logic [IX_W-1:0]           r_ixl;
    logic [15:0]               r_wx, r_wy;
    logic [ROW_W-1:0]          r_rem;
    logic signed [31:0]        r_vx, r_vy;
    logic                      r_absent;
    logic signed [POT_W-1:0]   r_pot [NPOT];
    logic signed [D_W-1:0]     r_d;
    logic signed [PLO_W-1:0]   r_plo;
    logic signed [TERM_W-1:0]  r_term [NTERM];
    logic signed [TERM_W-1:0]  r_lp [NLERP];
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [NY_W-1:0]           nyc;
    logic [ADDR_W-1:0]         sub_v;
    logic [ROW_W-1:0]          iyh, iym, iyhp, row;
    logic [COL_W-1:0]          col;
    logic [ADDR_W-1:0]         raddr, waddr;
    logic                      we;
    logic [POT_W-1:0]          rdata;
    logic signed [D_W-1:0]     d_w;
    logic signed [31:0]        scale, offset;
    logic signed [PLO_W-1:0]   plo_w;
    logic signed [PHI_W-1:0]   phi_w;
    logic signed [FULL_W-1:0]  full_w;
    logic signed [TERM_W-1:0]  la, lb;
    logic [15:0]               lw;
    logic signed [DIFF_W-1:0]  ldiff;
    logic signed [LPROD_W-1:0] lprod;
    logic signed [LSH_W-1:0]   lres;
    logic signed [SUM_W-1:0]   sx, sy;
    logic                      satx, saty;
    logic [2:0]                tj;

    // clamp rows in use, then derive neighbour rows with wrap
    always_comb begin
        if (i_cfg.ny_used < NY_W'(NY_MIN)) begin
            nyc = NY_W'(NY_MIN);
        end else if (i_cfg.ny_used > NY_W'(GRID_Y)) begin
            nyc = NY_W'(GRID_Y);
        end else begin
            nyc = i_cfg.ny_used;
        end
        sub_v = ADDR_W'(nyc) << i_cmd.idx[2:0];
        iyh   = (NY_W'(r_rem) + 1'b1 == nyc) ? '0 : r_rem + 1'b1;
        iym   = (r_rem == '0) ? ROW_W'(nyc - 1'b1) : r_rem - 1'b1;
        iyhp  = (NY_W'(iyh) + 1'b1 == nyc) ? '0 : iyh + 1'b1;
        unique case (pot_row(i_cmd.idx))
            ROW_L:   row = r_rem;
            ROW_H:   row = iyh;
            ROW_M:   row = iym;
            ROW_HP:  row = iyhp;
            default: row = r_rem;
        endcase
        col   = COL_W'(r_ixl) + COL_W'(pot_col_off(i_cmd.idx));
        raddr = ADDR_W'(row) * ADDR_W'(NCOLS) + ADDR_W'(col);
        waddr = ADDR_W'(i_item.cell_y) * ADDR_W'(NCOLS) + ADDR_W'(i_item.cell_x);
        we    = i_cmd.accept && (i_item.command == CMD_WRITE)
                && (32'(i_item.cell_x) < NCOLS) && (32'(i_item.cell_y) < GRID_Y);
    end

    pfg_ram #(
        .WIDTH (POT_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.potential),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // field term: difference plus offset, times scale in two halves
    always_comb begin
        tj     = i_cmd.idx[2:0];
        scale  = tj[2] ? i_cfg.ey_scale : i_cfg.ex_scale;
        offset = tj[2] ? i_cfg.ey_offset : i_cfg.ex_offset;
        d_w    = D_W'(r_pot[term_pos(tj)]) - D_W'(r_pot[term_neg(tj)]) + D_W'(offset);
        plo_w  = d_w * $signed({1'b0, scale[15:0]});
        phi_w  = r_d * $signed(scale[31:16]);
        full_w = (FULL_W'(phi_w) <<< 16) + FULL_W'(r_plo);
    end

    // interpolation step: lo + floor((hi - lo) * w / 2^16)
    always_comb begin
        unique case (i_cmd.idx[2:0])
            3'd0: begin la = r_term[0]; lb = r_term[1]; lw = r_wy; end
            3'd1: begin la = r_term[2]; lb = r_term[3]; lw = r_wy; end
            3'd2: begin la = r_lp[0];   lb = r_lp[1];   lw = r_wx; end
            3'd3: begin la = r_term[4]; lb = r_term[5]; lw = r_wy; end
            3'd4: begin la = r_term[6]; lb = r_term[7]; lw = r_wy; end
            default: begin la = r_lp[3]; lb = r_lp[4]; lw = r_wx; end
        endcase
        ldiff = DIFF_W'(lb) - DIFF_W'(la);
        lprod = ldiff * $signed({1'b0, lw});
        lres  = LSH_W'(la) + lprod[LPROD_W-1:16];
    end

    // velocity update with saturation
    always_comb begin
        sx   = SUM_W'(r_vx) + SUM_W'(r_lp[2]);
        sy   = SUM_W'(r_vy) + SUM_W'(r_lp[5]);
        satx = (sx[SUM_W-1:31] != {(SUM_W-31){sx[SUM_W-1]}});
        saty = (sy[SUM_W-1:31] != {(SUM_W-31){sy[SUM_W-1]}});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_item.command == CMD_PUSH) begin
            r_absent <= i_item.pos_x[31];
            r_vx     <= i_item.vel_x;
            r_vy     <= i_item.vel_y;
            r_wx     <= i_item.pos_x[15:0];
            r_wy     <= i_item.pos_y[15:0];
            r_rem    <= i_item.pos_y[21:16];
            if (i_item.pos_x[30:16] > 15'(GRID_X - 1)) begin
                r_ixl <= IX_W'(GRID_X - 1);
            end else begin
                r_ixl <= i_item.pos_x[16 +: IX_W];
            end
        end
        if (i_cmd.mod_step && (ADDR_W'(r_rem) >= sub_v)) begin
            r_rem <= r_rem - ROW_W'(sub_v);
        end
        if (i_cmd.cap_en) begin
            r_pot[i_cmd.idx - 1'b1] <= rdata;
        end
        if (i_cmd.mul_lo) begin
            r_d   <= d_w;
            r_plo <= plo_w;
        end
        if (i_cmd.mul_hi) begin
            r_term[tj] <= full_w[FULL_W-1:24];
        end
        if (i_cmd.lerp_en) begin
            r_lp[i_cmd.idx[2:0]] <= lres[TERM_W-1:0];
        end
        if (i_cmd.emit) begin
            if (r_absent) begin
                r_out.new_vel_x <= r_vx;
                r_out.new_vel_y <= r_vy;
                r_out.absent    <= 1'b1;
                r_out.saturated <= 1'b0;
            end else begin
                r_out.new_vel_x <= satx ? {sx[SUM_W-1], {31{!sx[SUM_W-1]}}} : sx[31:0];
                r_out.new_vel_y <= saty ? {sy[SUM_W-1], {31{!sy[SUM_W-1]}}} : sy[31:0];
                r_out.absent    <= 1'b0;
                r_out.saturated <= satx || saty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.push     = (i_item.command == CMD_PUSH);
    assign o_stat.absent   = i_item.pos_x[31];
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
endmodule
